// File: rtl/b64e_pkg.sv
// Shared types, codes and the character table of the credential Base64 encoder.
`default_nettype none

package b64e_pkg;

  // Function codes of an input item
  localparam logic [1:0] FN_NAME   = 2'd0;
  localparam logic [1:0] FN_PASS   = 2'd1;
  localparam logic [1:0] FN_FINISH = 2'd2;

  // Characters and limits
  localparam logic [7:0]  CH_PAD      = 8'h3D;  // '='
  localparam logic [7:0]  CH_COLON    = 8'h3A;  // ':'
  localparam logic [7:0]  CH_PLUS     = 8'h2B;  // '+'
  localparam logic [7:0]  CH_SLASH    = 8'h2F;  // '/'
  localparam logic [11:0] LEN_MAX     = 12'hFFF;
  localparam int          TEXT_BUFFER_SIZE = 1024;
  localparam logic [11:0] LIMIT_CAP   = 12'(TEXT_BUFFER_SIZE - 1);

  // One encoded group handed to the drain stage
  typedef struct packed {
    logic [3:0][7:0] chars;   // chars[0] goes out first
    logic [2:0]      count;   // results held, 1 to 4
    logic            last;    // final result closes the run
    logic            empty;   // finish marker without a character
    logic [11:0]     length;  // encoded length of the run
  } b64e_grp_t;

  // Map a six-bit code to its Base64 character
  function automatic logic [7:0] b64_char(input logic [5:0] code);
    logic [7:0] wide;
    wide = {2'b00, code};
    if (code < 6'd26)      b64_char = 8'(wide + 8'h41);
    else if (code < 6'd52) b64_char = 8'(wide + 8'h47);
    else if (code < 6'd62) b64_char = 8'(wide - 8'd4);
    else if (code == 6'd62) b64_char = CH_PLUS;
    else                   b64_char = CH_SLASH;
  endfunction

endpackage

`default_nettype wire

// File: rtl/b64e_core.sv
// Input register, run state and group encoding of the credential Base64 encoder.
`default_nettype none

module b64e_core
  import b64e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        cfg_wr_en,
  input  wire logic [9:0]  cfg_wr_data,
  input  wire logic        buf_ready,
  output logic             grp_valid,
  output b64e_grp_t        grp
);

  typedef struct packed {
    logic [15:0] b;
    logic [1:0]  c;
    logic        full;
    logic [23:0] abc;
  } push_t;

  // Append one byte to the open group
  function automatic push_t push_one(input logic [15:0] pb, input logic [1:0] pc,
                                     input logic [7:0] v);
    push_t r;
    r = '0;
    case (pc)
      2'd0: begin
        r.b = {v, 8'h00};
        r.c = 2'd1;
      end
      2'd1: begin
        r.b = {pb[15:8], v};
        r.c = 2'd2;
      end
      default: begin
        r.full = 1'b1;
        r.abc  = {pb, v};
      end
    endcase
    return r;
  endfunction

  logic        in_valid_r;
  logic [1:0]  func_r;
  logic [7:0]  byte_r;
  logic [9:0]  limit_r;
  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  pcnt_r, pcnt_nxt;
  logic        colon_r, colon_nxt;
  logic [11:0] emit_r, emit_nxt;
  logic [11:0] len_r, len_nxt;
  logic        take;
  logic        is_fin;
  logic        grp_full;
  logic [2:0]  n_chars;
  b64e_grp_t   grp_c;

  // Encode the item held in the input register
  always_comb begin : encode
    push_t       p;
    logic        colon_push;
    logic        do_first;
    logic        do_second;
    logic [7:0]  first_byte;
    logic [15:0] st_b;
    logic [1:0]  st_c;
    logic [23:0] abc;
    logic [1:0]  fill;
    logic [12:0] len_sum;
    logic [11:0] len_g;
    logic [11:0] limit;
    logic [11:0] room;
    logic [7:0]  c2;
    logic [7:0]  c3;

    is_fin     = (func_r == FN_FINISH);
    colon_push = ((func_r == FN_PASS) || is_fin) && !colon_r;
    do_first   = (func_r == FN_NAME) || (func_r == FN_PASS) || (is_fin && colon_push);
    do_second  = (func_r == FN_PASS) && colon_push;
    first_byte = colon_push ? CH_COLON : byte_r;

    st_b     = pend_r;
    st_c     = pcnt_r;
    grp_full = 1'b0;
    abc      = '0;
    fill     = 2'd0;
    p        = '0;

    if (do_first) begin
      p        = push_one(st_b, st_c, first_byte);
      st_b     = p.b;
      st_c     = p.c;
      grp_full = p.full;
      abc      = p.abc;
    end
    if (do_second) begin
      p    = push_one(st_b, st_c, byte_r);
      st_b = p.b;
      st_c = p.c;
      if (p.full) begin
        grp_full = 1'b1;
        abc      = p.abc;
      end
    end
    // Pad an open group at finish
    if (is_fin) begin
      if (st_c == 2'd1) begin
        grp_full = 1'b1;
        abc      = {st_b[15:8], 16'h0000};
        fill     = 2'd2;
      end else if (st_c == 2'd2) begin
        grp_full = 1'b1;
        abc      = {st_b, 8'h00};
        fill     = 2'd1;
      end
    end

    // Count the group into the length, saturating
    len_sum = {1'b0, len_r} + 13'd4;
    len_g   = grp_full ? (len_sum[12] ? LEN_MAX : len_sum[11:0]) : len_r;

    // Characters still allowed in this run
    limit = ({2'b00, limit_r} < LIMIT_CAP) ? {2'b00, limit_r} : LIMIT_CAP;
    room  = (emit_r >= limit) ? 12'd0 : 12'(limit - emit_r);
    if (!grp_full)          n_chars = 3'd0;
    else if (room >= 12'd4) n_chars = 3'd4;
    else                    n_chars = room[2:0];

    c2 = (fill == 2'd2) ? CH_PAD : b64_char({abc[11:8], abc[7:6]});
    c3 = (fill != 2'd0) ? CH_PAD : b64_char(abc[5:0]);

    grp_c.chars[0] = b64_char(abc[23:18]);
    grp_c.chars[1] = b64_char({abc[17:16], abc[15:12]});
    grp_c.chars[2] = c2;
    grp_c.chars[3] = c3;
    grp_c.count    = n_chars;
    grp_c.last     = is_fin;
    grp_c.empty    = 1'b0;
    grp_c.length   = len_g;
    // Finish with nothing to show gives a bare marker
    if (is_fin && (n_chars == 3'd0)) begin
      grp_c.chars = '0;
      grp_c.count = 3'd1;
      grp_c.empty = 1'b1;
    end

    // Next run state
    pend_nxt  = st_b;
    pcnt_nxt  = st_c;
    colon_nxt = colon_r | colon_push;
    emit_nxt  = 12'(emit_r + {9'd0, n_chars});
    len_nxt   = len_g;
    if (is_fin) begin
      pend_nxt  = '0;
      pcnt_nxt  = '0;
      colon_nxt = 1'b0;
      emit_nxt  = '0;
      len_nxt   = '0;
    end else if (!do_first) begin
      pend_nxt  = pend_r;
      pcnt_nxt  = pcnt_r;
      colon_nxt = colon_r;
      emit_nxt  = emit_r;
      len_nxt   = len_r;
    end
  end

  // Advance when the item has nothing to hand over or the drain stage can take it
  assign take      = in_valid_r && (((n_chars == 3'd0) && !is_fin) || buf_ready);
  assign in_stall  = in_valid_r && !take;
  assign grp_valid = take && ((n_chars != 3'd0) || is_fin);
  assign grp       = grp_c;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      func_r <= in_func;
      byte_r <= in_data_byte;
    end
  end

  // Run state and limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 10'd1023;
      pend_r  <= '0;
      pcnt_r  <= '0;
      colon_r <= 1'b0;
      emit_r  <= '0;
      len_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (take) begin
        pend_r  <= pend_nxt;
        pcnt_r  <= pcnt_nxt;
        colon_r <= colon_nxt;
        emit_r  <= emit_nxt;
        len_r   <= len_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/b64e_drain.sv
// Result register that shifts a group's characters out one per cycle while out_stall is low.
`default_nettype none

module b64e_drain
  import b64e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        grp_valid,
  input  wire b64e_grp_t   grp,
  output logic             buf_ready,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_text_char,
  output logic             out_is_last,
  output logic             out_is_empty,
  output logic [11:0]      out_total_length
);

  logic [3:0][7:0] chars_r;
  logic [2:0]      cnt_r;
  logic            last_r;
  logic            empty_r;
  logic [11:0]     len_r;
  logic            pop;

  assign out_valid        = (cnt_r != 3'd0);
  assign pop              = out_valid && !out_stall;
  assign buf_ready        = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && !out_stall);
  assign out_text_char    = chars_r[0];
  assign out_is_last      = last_r && (cnt_r == 3'd1);
  assign out_is_empty     = empty_r;
  assign out_total_length = len_r;

  // Load a new group or shift the next character forward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (grp_valid) begin
      cnt_r <= grp.count;
    end else if (pop) begin
      cnt_r <= 3'(cnt_r - 3'd1);
    end
    if (grp_valid) begin
      chars_r <= grp.chars;
      last_r  <= grp.last;
      empty_r <= grp.empty;
      len_r   <= grp.length;
    end else if (pop) begin
      chars_r <= {8'h00, chars_r[3:1]};
    end
  end

endmodule

`default_nettype wire

// File: rtl/credential_base64_encoder.sv
// Top level of the credential Base64 encoder: encoding core and drain register.
//
//   channel  | ports                                          | direction
//   ---------+------------------------------------------------+----------
//   in       | in_valid, in_stall, in_func, in_data_byte      | to block
//   out      | out_valid, out_stall, out_text_char,           | from block
//            | out_is_last, out_is_empty, out_total_length    |
//   cfg      | cfg_wr_en, cfg_wr_data (char_limit)            | to block
//
// A byte item that leaves its group open never waits in the input register. An
// item that completes or pads a group loads up to four characters into the drain
// register; a new group is taken as the last character leaves.
// A result passes through the input register and then the drain register.
// Reset is synchronous and clears the run state and sets char_limit to 1023.
// out_stall freezes the drain register and, when it is busy, any item with output.
`default_nettype none

module credential_base64_encoder
  import b64e_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_text_char,
  output logic             out_is_last,
  output logic             out_is_empty,
  output logic [11:0]      out_total_length,
  input  wire logic        cfg_wr_en,
  input  wire logic [9:0]  cfg_wr_data
);

  logic      grp_valid;
  logic      buf_ready;
  b64e_grp_t grp;

  b64e_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .buf_ready    (buf_ready),
    .grp_valid    (grp_valid),
    .grp          (grp)
  );

  b64e_drain u_drain (
    .clk              (clk),
    .rst_n            (rst_n),
    .grp_valid        (grp_valid),
    .grp              (grp),
    .buf_ready        (buf_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_text_char    (out_text_char),
    .out_is_last      (out_is_last),
    .out_is_empty     (out_is_empty),
    .out_total_length (out_total_length)
  );

`ifndef SYNTH
  // A group is only handed over when the drain register has room
  a_grp_room: assert property (@(posedge clk) disable iff (!rst_n)
    grp_valid |-> buf_ready)
    else $error("group handed to a busy drain register");

  // A handed-over group shows a result in the next cycle
  a_grp_shown: assert property (@(posedge clk) disable iff (!rst_n)
    grp_valid |=> out_valid)
    else $error("group lost in the drain register");

  // A bare finish marker carries no character and closes the run
  a_empty_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_is_last && (out_text_char == 8'h00)))
    else $error("empty result is not a clean finish marker");
`endif

endmodule

`default_nettype wire

// File: bench/b64e_tb_pkg.sv
// Scoreboard class that predicts and checks the Base64 text of the credential encoder.
package b64e_tb_pkg;
  import b64e_pkg::*;

  // Function code that the encoder ignores
  localparam logic [1:0] FN_UNUSED = 2'd3;

  // One character result as it leaves the encoder
  typedef struct {
    logic [7:0]  text_char;
    logic        is_last;
    logic        is_empty;
    logic [11:0] total_length;
  } b64_result_t;

  class b64_text_tracker;
    string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [9:0]  char_limit = 10'd1023;
    logic [15:0] held_bytes = '0;
    logic [1:0]  held_count = '0;
    logic        colon_done = 1'b0;
    logic [11:0] emitted = '0;
    logic [11:0] text_length = '0;
    int          step_chars;
    b64_result_t awaited_chars[$];
    int          items_taken;
    int          chars_checked;
    int          credentials_closed;
    int          failures;

    function void set_limit(logic [9:0] value);
      char_limit = value;
    endfunction

    function int pending();
      return awaited_chars.size();
    endfunction

    function logic [7:0] sextet_char(logic [5:0] code);
      return alphabet[code];
    endfunction

    // Queue one character unless the emit limit has been reached
    function void put_text_char(logic [7:0] ch);
      b64_result_t r;
      logic [11:0] cap;
      cap = (12'(char_limit) < LIMIT_CAP) ? 12'(char_limit) : LIMIT_CAP;
      if (emitted < cap && step_chars < 4) begin
        r.text_char    = ch;
        r.is_last      = 1'b0;
        r.is_empty     = 1'b0;
        r.total_length = text_length;
        awaited_chars.push_back(r);
        emitted++;
        step_chars++;
      end
    endfunction

    // Turn three bytes into four characters; pad counts the missing bytes
    function void encode_group(logic [7:0] a, logic [7:0] b, logic [7:0] c, int pad);
      text_length = (text_length > LEN_MAX - 12'd4) ? LEN_MAX : text_length + 12'd4;
      put_text_char(sextet_char(a[7:2]));
      put_text_char(sextet_char({a[1:0], b[7:4]}));
      put_text_char(pad == 2 ? CH_PAD : sextet_char({b[3:0], c[7:6]}));
      put_text_char(pad >= 1 ? CH_PAD : sextet_char(c[5:0]));
    endfunction

    // Hold the first two bytes of a group, encode on the third
    function void push_credential_byte(logic [7:0] v);
      case (held_count)
        2'd0: begin
          held_bytes = {v, 8'h00};
          held_count = 2'd1;
        end
        2'd1: begin
          held_bytes[7:0] = v;
          held_count = 2'd2;
        end
        default: begin
          encode_group(held_bytes[15:8], held_bytes[7:0], v, 0);
          held_bytes = '0;
          held_count = 2'd0;
        end
      endcase
    endfunction

    function void insert_colon();
      if (!colon_done) begin
        push_credential_byte(CH_COLON);
        colon_done = 1'b1;
      end
    endfunction

    // Note an accepted input item and queue the characters it yields
    function void absorb_item(logic [1:0] func, logic [7:0] data_byte);
      b64_result_t r;
      items_taken++;
      step_chars = 0;
      case (func)
        FN_NAME: push_credential_byte(data_byte);
        FN_PASS: begin
          insert_colon();
          push_credential_byte(data_byte);
        end
        FN_FINISH: begin
          insert_colon();
          if (held_count == 2'd1)
            encode_group(held_bytes[15:8], 8'h00, 8'h00, 2);
          else if (held_count == 2'd2)
            encode_group(held_bytes[15:8], held_bytes[7:0], 8'h00, 1);
          // nothing left to emit: a bare end marker
          if (step_chars == 0) begin
            r.text_char    = 8'h00;
            r.is_last      = 1'b0;
            r.is_empty     = 1'b1;
            r.total_length = text_length;
            awaited_chars.push_back(r);
          end
          r = awaited_chars.pop_back();
          r.is_last = 1'b1;
          awaited_chars.push_back(r);
          held_bytes = '0;
          held_count = 2'd0;
          colon_done = 1'b0;
          emitted = '0;
          text_length = '0;
          credentials_closed++;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        failures++;
      end
    endfunction

    // Check an accepted result against the oldest awaited character
    function void check_char(logic [7:0] ch, logic last, logic empty, logic [11:0] len);
      b64_result_t want;
      chars_checked++;
      if (awaited_chars.size() == 0) begin
        $error("result with none awaited: text_char %0h is_last %b is_empty %b total_length %0d",
               ch, last, empty, len);
        failures++;
        return;
      end
      want = awaited_chars.pop_front();
      compare_field("text_char", 12'(want.text_char), 12'(ch));
      compare_field("is_last", 12'(want.is_last), 12'(last));
      compare_field("is_empty", 12'(want.is_empty), 12'(empty));
      compare_field("total_length", want.total_length, len);
    endfunction
  endclass

endpackage

// File: bench/testbench.sv
// Top-level testbench of the credential Base64 encoder: stimulus, stalls and checking.
module testbench
  import b64e_pkg::*, b64e_tb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS = 200;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_text_char;
  logic        out_is_last;
  logic        out_is_empty;
  logic [11:0] out_total_length;
  logic        cfg_wr_en;
  logic [9:0]  cfg_wr_data;

  b64_text_tracker tracker;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int items_sent = 0;
  int stuck_cycles = 0;

  credential_base64_encoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_text_char    (out_text_char),
    .out_is_last      (out_is_last),
    .out_is_empty     (out_is_empty),
    .out_total_length (out_total_length),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        tracker.check_char(out_text_char, out_is_last, out_is_empty, out_total_length);
      if (in_valid && !in_stall)
        tracker.absorb_item(in_func, in_data_byte);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: stall in random bursts, or hold off for a long stretch on request
  initial begin
    bit lvl;
    bit holding;
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      holding = 1'b0;
      if (hold_req) begin
        lvl = 1'b1;
        n = HOLD_CYCLES;
        holding = 1'b1;
      end else if (quiet || $urandom_range(0, 1) == 0) begin
        lvl = 1'b0;
        n = $urandom_range(1, 16);
      end else begin
        lvl = 1'b1;
        n = $urandom_range(1, 16);
      end
      out_stall <= lvl;
      repeat (n - 1) @(negedge clk);
      if (holding)
        hold_req = 1'b0;
    end
  end

  // Offer one item, after an optional random gap, and wait until it is taken
  task automatic send_item(logic [1:0] func, logic [7:0] data_byte);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_func      <= func;
    in_data_byte <= data_byte;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (func != FN_UNUSED)
      items_sent++;
  endtask

  // Drop valid, then wait until every awaited character has come and the block settles
  task automatic drain_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0 || hold_req) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(logic [9:0] value);
    drain_wait();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_limit(value);
  endtask

  // One credential: name bytes, password bytes, finish, with occasional odd items
  task automatic send_credential(int name_len, int pass_len);
    for (int i = 0; i < name_len; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(FN_UNUSED, 8'($urandom));
      send_item(FN_NAME, 8'($urandom));
    end
    for (int i = 0; i < pass_len; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_item(FN_NAME, 8'($urandom));
      send_item(FN_PASS, 8'($urandom));
    end
    send_item(FN_FINISH, 8'($urandom));
  endtask

  initial begin
    bit held_off;
    bit paused;
    tracker = new;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_func      = FN_NAME;
    in_data_byte = 8'h00;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 10'd0;
    held_off     = 1'b0;
    paused       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty credential, whole-group name, mixed order, tight limits
    set_limit(10'd1023);
    send_item(FN_FINISH, 8'h00);
    send_item(FN_NAME, 8'h00);
    send_item(FN_NAME, 8'hFF);
    send_item(FN_NAME, 8'h80);
    send_item(FN_FINISH, 8'hFF);
    send_item(FN_NAME, 8'h41);
    send_item(FN_PASS, 8'h7F);
    send_item(FN_NAME, 8'h01);
    send_item(FN_UNUSED, 8'hAA);
    send_item(FN_PASS, 8'hFF);
    send_item(FN_FINISH, 8'h00);
    set_limit(10'd0);
    send_item(FN_NAME, 8'h55);
    send_item(FN_FINISH, 8'h00);
    set_limit(10'd1);
    send_item(FN_FINISH, 8'h00);
    set_limit(10'd5);
    send_item(FN_PASS, 8'h10);
    send_item(FN_PASS, 8'h20);
    send_item(FN_PASS, 8'h30);
    send_item(FN_FINISH, 8'h00);
    set_limit(10'd1023);

    // Random credentials with occasional limit changes and broken sequences
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= RANDOM_ITEMS * 4 / 5)
        quiet = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: set_limit(10'($urandom_range(0, 12)));
          1: set_limit(10'd1023);
          default: set_limit(10'($urandom));
        endcase
      end
      if (!held_off && items_sent >= 70) begin
        // long receiver hold-off while the sender keeps offering items
        held_off = 1'b1;
        hold_req = 1'b1;
        send_credential(15, 6);
      end else if (!paused && items_sent >= 120) begin
        paused = 1'b1;
        drain_wait();
      end else if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 8))
          send_item(2'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        send_credential($urandom_range(0, 7), $urandom_range(0, 7));
      end
    end

    drain_wait();
    $display("Covered %0d items over %0d finished credentials, %0d characters checked",
             tracker.items_taken, tracker.credentials_closed, tracker.chars_checked);
    $display("Limits 0 to 1023, padding, colon insertion and input back-pressure exercised");
    if (tracker.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
